// File: hw/rtl/stf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stf_pkg: shared types and constants of the STEP statement type filter
// Word formats, prefix phases, controller states and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package stf_pkg;

  // type name whose statements are removed, upper case
  localparam int NAME_LEN = 14;
  localparam logic [8*NAME_LEN-1:0] TYPE_NAME = "IFCFOOTINGTYPE";

  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_QUOTE = 8'h27;  // '\''
  localparam logic [7:0] CH_UNDER = 8'h5F;  // '_'

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } stf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_end;
    logic       prefix_overflow;
  } stf_out_t;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_WS_BEFORE_EQ,
    PH_WS_AFTER_EQ,
    PH_NAME,
    PH_PASS,
    PH_DROP
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_HOLD,
    ACT_KEEP,
    ACT_DROP
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_CUR
  } state_t;

  // source of the next word loaded into the output register
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_IN,
    SRC_MEM,
    SRC_SAVED
  } out_src_t;

  typedef struct packed {
    logic     accept;
    logic     rd_issue;
    out_src_t src;
  } stf_cmd_t;

  typedef struct packed {
    logic acc_rel_zero;  // incoming word releases no held bytes
    logic acc_out;       // incoming word yields its own result (byte or marker)
    logic last_rel;      // release index is at the last held byte
    logic sv_emit;       // saved word carries a byte after the release
    logic out_free;      // output register can take a word this cycle
  } stf_stat_t;

  // character of the type name at a position, 0 past the end
  function automatic logic [7:0] name_byte(input logic [3:0] idx);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < NAME_LEN; i++) begin
      if (idx == 4'(i)) begin
        r = TYPE_NAME[(NAME_LEN-1-i)*8 +: 8];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/stf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stf_ctrl: sequencing controller
// Accepts words, steps through the release of held prefix bytes and places
// the current byte or end marker after them.
// ----------------------------------------------------------------------------
module stf_ctrl import stf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire stf_stat_t stat,
  output stf_cmd_t       cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.rd_issue = 1'b0;
    cmd.src      = SRC_NONE;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!stat.acc_rel_zero) begin
            state_next = ST_RD;
          end else if (stat.acc_out) begin
            if (stat.out_free) begin
              cmd.src = SRC_IN;
            end else begin
              state_next = ST_CUR;
            end
          end
        end
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_WR;
      end
      ST_WR: begin
        if (stat.out_free) begin
          cmd.src = SRC_MEM;
          if (!stat.last_rel) begin
            state_next = ST_RD;
          end else if (stat.sv_emit) begin
            state_next = ST_CUR;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_CUR: begin
        if (stat.out_free) begin
          cmd.src    = SRC_SAVED;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // a word is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.src != SRC_NONE |-> stat.out_free)
    else $error("output loaded while occupied");

  // a release read is always followed by its write-out step
  a_rd_then_wr: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |=> state == ST_WR)
    else $error("release read not followed by write-out");

  // a word is taken only while offered and ready
  a_accept_hs: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> in_valid && in_ready)
    else $error("word taken without handshake");

endmodule
`default_nettype wire

// File: hw/rtl/stf_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stf_dpath: prefix classifier, hold memory and output register
// Classifies each byte against the statement prefix, keeps the held bytes in
// a memory and drives the output word.
// ----------------------------------------------------------------------------
module stf_dpath import stf_pkg::*; #(
  parameter int HOLD_DEPTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire stf_in_t  in_data,
  input  wire stf_cmd_t cmd,
  output stf_stat_t     stat,
  output logic          out_valid,
  input  wire logic     out_ready,
  output stf_out_t      out_data
);

  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam int IW = $clog2(HOLD_DEPTH);

  // statement state
  logic          inside_string;
  phase_t        prefix_phase;
  logic [3:0]    name_match_count;
  logic [CW-1:0] held_count;

  logic [7:0] held_bytes [HOLD_DEPTH];
  logic [7:0] rdata;

  // saved word and release progress
  logic [7:0]    sv_byte;
  logic          sv_ovf;
  logic          sv_eot;
  logic          sv_emit;
  logic [CW-1:0] rel_cnt;
  logic [CW-1:0] rd_idx;

  // classification of the incoming byte
  logic [7:0]    b;
  logic [7:0]    b_up;
  logic          is_ws, is_digit, is_name;
  act_t          act;
  phase_t        ph_hold;
  logic [3:0]    cnt_hold;
  logic          hold_ok, ovf, keep, drop;
  phase_t        eff_phase;
  logic          eff_prefix;
  logic [CW-1:0] held_after;
  logic          emit_cur;
  logic [CW-1:0] rel_n;
  logic          marker;
  logic          new_stmt;
  logic          toggle;
  logic          eot;

  always_comb begin
    b        = in_data.in_byte;
    eot      = in_data.end_of_text;
    is_ws    = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    is_digit = (b >= 8'h30 && b <= 8'h39);
    is_name  = is_digit || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A) || (b == CH_UNDER);
    b_up     = (b >= 8'h61 && b <= 8'h7A) ? (b - 8'd32) : b;

    act      = ACT_KEEP;
    ph_hold  = prefix_phase;
    cnt_hold = name_match_count;
    case (prefix_phase)
      PH_LEAD: begin
        if (is_ws) begin
          act = ACT_HOLD;
        end else if (b == CH_HASH) begin
          act = ACT_HOLD; ph_hold = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          act = ACT_HOLD;
        end else if (is_ws) begin
          act = ACT_HOLD; ph_hold = PH_WS_BEFORE_EQ;
        end else if (b == CH_EQ) begin
          act = ACT_HOLD; ph_hold = PH_WS_AFTER_EQ;
        end
      end
      PH_WS_BEFORE_EQ: begin
        if (is_ws) begin
          act = ACT_HOLD;
        end else if (b == CH_EQ) begin
          act = ACT_HOLD; ph_hold = PH_WS_AFTER_EQ;
        end
      end
      PH_WS_AFTER_EQ: begin
        if (is_ws) begin
          act = ACT_HOLD;
        end else if (is_name && b_up == name_byte(4'd0)) begin
          act = ACT_HOLD; ph_hold = PH_NAME; cnt_hold = 4'd1;
        end
      end
      PH_NAME: begin
        if (is_name) begin
          if (name_match_count < 4'(NAME_LEN) && b_up == name_byte(name_match_count)) begin
            act = ACT_HOLD; cnt_hold = name_match_count + 4'd1;
          end
        end else if (name_match_count == 4'(NAME_LEN)) begin
          act = ACT_DROP;
        end
      end
      default: begin
        act = ACT_NONE;
      end
    endcase

    // full hold buffer turns a hold into a kept statement
    hold_ok = (act == ACT_HOLD) && (held_count < CW'(HOLD_DEPTH));
    ovf     = (act == ACT_HOLD) && !hold_ok;
    keep    = (act == ACT_KEEP) || ovf;
    drop    = (act == ACT_DROP);

    if (hold_ok)   eff_phase = ph_hold;
    else if (keep) eff_phase = PH_PASS;
    else if (drop) eff_phase = PH_DROP;
    else           eff_phase = prefix_phase;
    eff_prefix = (eff_phase != PH_PASS) && (eff_phase != PH_DROP);

    if (hold_ok)           held_after = held_count + CW'(1);
    else if (keep || drop) held_after = '0;
    else                   held_after = held_count;

    emit_cur = (eff_phase == PH_PASS);
    toggle   = !eff_prefix && (b == CH_QUOTE);
    new_stmt = !eff_prefix && (b == CH_SEMI) && !inside_string;

    // held bytes released by this word: on keep, or flushed at end of text
    if (keep)                   rel_n = held_count;
    else if (eot && eff_prefix) rel_n = held_after;
    else                        rel_n = '0;
    marker = eot && (rel_n == '0) && !emit_cur;
  end

  // statement state update
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_string    <= 1'b0;
      prefix_phase     <= PH_LEAD;
      name_match_count <= 4'd0;
      held_count       <= '0;
    end else if (cmd.accept) begin
      if (eot || new_stmt) begin
        prefix_phase     <= PH_LEAD;
        name_match_count <= 4'd0;
        held_count       <= '0;
      end else begin
        prefix_phase     <= eff_phase;
        name_match_count <= hold_ok ? cnt_hold : name_match_count;
        held_count       <= held_after;
      end
      inside_string <= eot ? 1'b0 : (inside_string ^ toggle);
    end
  end

  // hold memory: one write at accept, registered read during release
  always_ff @(posedge clk) begin
    if (cmd.accept && hold_ok) begin
      held_bytes[held_count[IW-1:0]] <= b;
    end
    if (cmd.rd_issue) begin
      rdata <= held_bytes[rd_idx[IW-1:0]];
    end
  end

  // saved word and release counter
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sv_byte <= b;
      sv_ovf  <= ovf;
      sv_eot  <= eot;
      sv_emit <= emit_cur;
      rel_cnt <= rel_n;
      rd_idx  <= '0;
    end else if (cmd.src == SRC_MEM) begin
      rd_idx <= rd_idx + CW'(1);
    end
  end

  // output register
  logic     out_free;
  logic     last_rel;
  stf_out_t out_next;

  assign out_free = !out_valid || out_ready;
  assign last_rel = (rd_idx == rel_cnt - CW'(1));

  always_comb begin
    out_next = out_data;
    case (cmd.src)
      SRC_IN: begin
        out_next.out_byte        = emit_cur ? b : 8'h00;
        out_next.byte_valid      = emit_cur;
        out_next.run_last        = 1'b1;
        out_next.stream_end      = eot;
        out_next.prefix_overflow = ovf && emit_cur;
      end
      SRC_MEM: begin
        out_next.out_byte        = rdata;
        out_next.byte_valid      = 1'b1;
        out_next.run_last        = last_rel && !sv_emit;
        out_next.stream_end      = last_rel && !sv_emit && sv_eot;
        out_next.prefix_overflow = sv_ovf;
      end
      SRC_SAVED: begin
        out_next.out_byte        = sv_emit ? sv_byte : 8'h00;
        out_next.byte_valid      = sv_emit;
        out_next.run_last        = 1'b1;
        out_next.stream_end      = sv_eot;
        out_next.prefix_overflow = sv_ovf && sv_emit;
      end
      default: begin
        out_next = out_data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.src != SRC_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_next;
  end

  // status to the controller
  always_comb begin
    stat.acc_rel_zero = (rel_n == '0);
    stat.acc_out      = emit_cur || marker;
    stat.last_rel     = last_rel;
    stat.sv_emit      = sv_emit;
    stat.out_free     = out_free;
  end

  // hold count never passes the memory depth
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(HOLD_DEPTH))
    else $error("held count beyond hold depth");

  // end of text returns the statement state to its start
  a_eot_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && eot |=> held_count == '0 && prefix_phase == PH_LEAD && !inside_string)
    else $error("state not cleared after end of text");

  // release reads stay within the bytes actually held
  a_rd_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> rd_idx < rel_cnt)
    else $error("release read past held bytes");

endmodule
`default_nettype wire

// File: hw/rtl/step_statement_type_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// step_statement_type_filter: STEP statement type filter
// Removes every IFCFOOTINGTYPE instance statement from a STEP byte stream.
// ----------------------------------------------------------------------------
// Bytes in, filtered bytes out, one word per byte on valid/ready channels.
// A byte that releases nothing held and finds the output register free
// is loaded into it when it yields a word, and the next byte is accepted
// in the following cycle even while its result still sits in the output
// register; an occupied output register holds the input back. Bytes of a
// statement prefix are held in a single-port hold memory of HOLD_DEPTH
// entries with a registered read; when the prefix is resolved as kept, or
// the text ends during a prefix, the n held bytes come out one by one (read,
// then load of the output register), followed by the current byte when it
// is kept; when the text ends during a prefix, the current byte is one of
// the n. A prefix longer than HOLD_DEPTH is flagged with prefix_overflow and
// kept. A last byte that yields no word gives one end marker word
// (byte_valid 0); stream_end is set on the last word of the text.
// ----------------------------------------------------------------------------
module step_statement_type_filter import stf_pkg::*; #(
  parameter int HOLD_DEPTH = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire stf_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output stf_out_t     out_data
);

  stf_cmd_t  cmd;
  stf_stat_t stat;

  // sequencing
  stf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // classification, hold memory and output register
  stf_dpath #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: tb/sv/stf_filter_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stf_filter_check: result checker for the STEP statement type filter
// Watches both word channels. Every accepted input byte runs through a local
// copy of the filter rules, and the words it should cause are queued. Every
// accepted output word is compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module stf_filter_check import stf_pkg::*; #(
  parameter int HOLD_DEPTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  stf_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  stf_out_t out_data,
  output int       fail_count,
  output int       pending
);

  // filter state
  logic       in_str;
  phase_t     phase;
  int         match_cnt;
  logic       still_match;
  logic [7:0] held [HOLD_DEPTH];
  int         held_cnt;

  stf_out_t   run_q[$];   // words caused by the byte being filtered
  stf_out_t   filtered_q[$];  // filtered words not yet seen on the output
  int         errs = 0;

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_num(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_name_byte(input logic [7:0] b);
    return is_num(b) || (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
           b == CH_UNDER;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
  endfunction

  function automatic logic [7:0] type_char(input int idx);
    return TYPE_NAME[(NAME_LEN-1-idx)*8 +: 8];
  endfunction

  task automatic start_statement();
    phase       = PH_LEAD;
    match_cnt   = 0;
    still_match = 1'b1;
    held_cnt    = 0;
  endtask

  task automatic add_word(input logic [7:0] b, input logic v, input logic ovf);
    stf_out_t w;
    w.out_byte        = b;
    w.byte_valid      = v;
    w.run_last        = 1'b0;
    w.stream_end      = 1'b0;
    w.prefix_overflow = ovf;
    run_q = {run_q, w};
  endtask

  task automatic release_held(input logic ovf);
    for (int i = 0; i < held_cnt; i++) add_word(held[i], 1'b1, ovf);
    held_cnt = 0;
  endtask

  // one input byte: prefix decision, pass or drop, end of text
  task automatic filter_byte(input stf_in_t w);
    logic [7:0] b;
    act_t       act;
    phase_t     nxt;
    logic       ovf;
    stf_out_t   t;
    b   = w.in_byte;
    ovf = 1'b0;
    run_q.delete();

    if (phase < PH_PASS) begin
      act = ACT_KEEP;
      nxt = phase;
      case (phase)
        PH_LEAD: begin
          if (is_space(b)) begin
            act = ACT_HOLD;
          end else if (b == CH_HASH) begin
            act = ACT_HOLD;
            nxt = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          if (is_num(b)) begin
            act = ACT_HOLD;
          end else if (is_space(b)) begin
            act = ACT_HOLD;
            nxt = PH_WS_BEFORE_EQ;
          end else if (b == CH_EQ) begin
            act = ACT_HOLD;
            nxt = PH_WS_AFTER_EQ;
          end
        end
        PH_WS_BEFORE_EQ: begin
          if (is_space(b)) begin
            act = ACT_HOLD;
          end else if (b == CH_EQ) begin
            act = ACT_HOLD;
            nxt = PH_WS_AFTER_EQ;
          end
        end
        PH_WS_AFTER_EQ: begin
          if (is_space(b)) begin
            act = ACT_HOLD;
          end else if (is_name_byte(b)) begin
            if (upcase(b) == type_char(0)) begin
              act       = ACT_HOLD;
              nxt       = PH_NAME;
              match_cnt = 1;
            end else begin
              still_match = 1'b0;
            end
          end
        end
        default: begin
          // type name: any non-name byte ends it
          if (is_name_byte(b)) begin
            if (match_cnt < NAME_LEN && upcase(b) == type_char(match_cnt)) begin
              act = ACT_HOLD;
              match_cnt++;
            end else begin
              still_match = 1'b0;
            end
          end else if (still_match && match_cnt == NAME_LEN) begin
            act = ACT_DROP;
          end
        end
      endcase

      // a full hold buffer turns a hold into a flagged keep
      if (act == ACT_HOLD) begin
        if (held_cnt >= HOLD_DEPTH) begin
          act = ACT_KEEP;
          ovf = 1'b1;
        end else begin
          held[held_cnt] = b;
          held_cnt++;
          phase = nxt;
        end
      end
      if (act == ACT_KEEP) begin
        release_held(ovf);
        phase = PH_PASS;
      end else if (act == ACT_DROP) begin
        held_cnt = 0;
        phase    = PH_DROP;
      end
    end

    // statement body: quotes toggle string mode, ';' outside ends it
    if (phase == PH_PASS || phase == PH_DROP) begin
      if (phase == PH_PASS) add_word(b, 1'b1, ovf);
      if (b == CH_QUOTE) begin
        in_str = ~in_str;
      end else if (b == CH_SEMI && !in_str) begin
        start_statement();
      end
    end

    // end of text: flush an open prefix, marker if nothing came out
    if (w.end_of_text) begin
      if (phase < PH_PASS) release_held(1'b0);
      if (run_q.size() == 0) add_word(8'h00, 1'b0, 1'b0);
      t = run_q[run_q.size()-1];
      t.stream_end = 1'b1;
      run_q[run_q.size()-1] = t;
      in_str = 1'b0;
      start_statement();
    end

    if (run_q.size() > 0) begin
      t = run_q[run_q.size()-1];
      t.run_last = 1'b1;
      run_q[run_q.size()-1] = t;
    end
    filtered_q = {filtered_q, run_q};
  endtask

  task automatic check_word(input stf_out_t got);
    stf_out_t want;
    if (filtered_q.size() == 0) begin
      errs++;
      if (errs <= 10) begin
        $display("[%0t] unexpected word: byte %02h valid %b last %b end %b ovf %b",
                 $realtime, got.out_byte, got.byte_valid, got.run_last,
                 got.stream_end, got.prefix_overflow);
      end
    end else begin
      want = filtered_q.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.run_last !== want.run_last || got.stream_end !== want.stream_end ||
          got.prefix_overflow !== want.prefix_overflow) begin
        errs++;
        if (errs <= 10) begin
          $display("[%0t] word mismatch: byte %02h/%02h valid %b/%b last %b/%b end %b/%b ovf %b/%b (expected/actual)",
                   $realtime, want.out_byte, got.out_byte, want.byte_valid,
                   got.byte_valid, want.run_last, got.run_last, want.stream_end,
                   got.stream_end, want.prefix_overflow, got.prefix_overflow);
        end
      end
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      in_str = 1'b0;
      start_statement();
      filtered_q.delete();
    end else begin
      if (in_valid && in_ready) filter_byte(in_data);
      if (out_valid && out_ready) check_word(out_data);
    end
    fail_count <= errs;
    pending    <= filtered_q.size();
  end

endmodule

// File: tb/sv/tb_step_statement_type_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_step_statement_type_filter: testbench of the STEP statement type filter
// Feeds short directed texts, then random STEP-like texts built mostly from
// well-formed instance statements (matching, near-miss and overlong prefixes,
// quoted strings, truncated endings), with random gaps on the input and
// random stalls on the output. Checking is done by stf_filter_check.
// ----------------------------------------------------------------------------
module tb_step_statement_type_filter;
  import stf_pkg::*;

  localparam int HOLD_DEPTH = 32;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  stf_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  stf_out_t out_data;
  int       fail_count;
  int       pending;

  logic [7:0] text_q[$];  // bytes of the text being built
  int         sent_cnt = 0;
  bit         calm     = 1'b0;  // no gaps and no stalls while set

  always #5 clk = ~clk;

  step_statement_type_filter #(
    .HOLD_DEPTH(HOLD_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  stf_filter_check #(
    .HOLD_DEPTH(HOLD_DEPTH)
  ) u_filter_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // mostly short idle stretches, a few long ones
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] ws_byte();
    int r;
    r = $urandom_range(0, 5);
    return (r == 0) ? 8'h20 : 8'(8'h08 + r);
  endfunction

  task automatic put(input logic [7:0] b);
    text_q = {text_q, b};
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_ws(input int n);
    repeat (n) put(ws_byte());
  endtask

  task automatic put_digits(input int n);
    repeat (n) put(8'h30 + 8'($urandom_range(0, 9)));
  endtask

  // type name in random case; len past NAME_LEN appends 'S', bad_pos spoils one byte
  task automatic put_name(input int len, input int bad_pos);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      c = (i < NAME_LEN) ? TYPE_NAME[(NAME_LEN-1-i)*8 +: 8] : 8'h53;
      if (i == bad_pos) c = $urandom_range(0, 1) ? CH_UNDER : 8'h51;
      if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1)) c = c + 8'd32;
      put(c);
    end
  endtask

  // argument list with numbers, references and quoted strings
  task automatic put_body();
    int n;
    n = $urandom_range(0, 3);
    put_str("(");
    for (int i = 0; i < n; i++) begin
      if (i > 0) put_str(",");
      case ($urandom_range(0, 4))
        0: put_digits($urandom_range(1, 3));
        1: begin
          // string content may hold ';' and doubled quotes
          put(CH_QUOTE);
          repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 3))
              0: put_str("x");
              1: put(CH_SEMI);
              2: begin
                put(CH_QUOTE);
                put(CH_QUOTE);
              end
              default: put_str(" #");
            endcase
          end
          put(CH_QUOTE);
        end
        2: put_str("$");
        3: put_str("#12");
        default: put_str(".T.");
      endcase
    end
    put_str(")");
    put(CH_SEMI);
    if ($urandom_range(0, 1)) put(8'h0A);
  endtask

  task automatic add_statement();
    int r;
    int v;
    r = $urandom_range(0, 99);
    // noise ended by ';'
    if (r < 8) begin
      repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
      put(CH_SEMI);
      return;
    end
    // prefix around the hold buffer size
    if (r < 13) begin
      if (r < 10) begin
        put_ws($urandom_range(HOLD_DEPTH - 3, HOLD_DEPTH + 4));
        put(CH_HASH);
        put_digits(1);
      end else begin
        put(CH_HASH);
        put_digits($urandom_range(HOLD_DEPTH - 3, HOLD_DEPTH + 4));
      end
      put(CH_EQ);
      put_name(NAME_LEN, -1);
      put_body();
      return;
    end
    // instance statement, sometimes without '#' or '='
    put_ws($urandom_range(0, 2));
    if (r >= 18) put(CH_HASH);
    put_digits($urandom_range(0, 3));
    put_ws($urandom_range(0, 1));
    if (r < 18 || r >= 23) put(CH_EQ);
    put_ws($urandom_range(0, 1));
    v = $urandom_range(0, 9);
    if (v <= 5) put_name(NAME_LEN, -1);
    else if (v == 6) put_name($urandom_range(1, NAME_LEN - 1), -1);
    else if (v == 7) put_name(NAME_LEN + 1, -1);
    else if (v == 8) put_name(NAME_LEN, $urandom_range(0, NAME_LEN - 1));
    else if ($urandom_range(0, 1)) put_str("IfcWall");
    // name terminator
    case ($urandom_range(0, 9))
      7: begin
        put(ws_byte());
        put_body();
      end
      8: put(CH_SEMI);
      9: begin
        put(8'($urandom_range(128, 255)));
        put_body();
      end
      default: put_body();
    endcase
  endtask

  // drive one word at the falling edge and hold it until accepted
  task automatic send_word(input stf_in_t w);
    int gap;
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // send the built text, end_of_text on its last byte
  task automatic send_text();
    stf_in_t w;
    for (int i = 0; i < text_q.size(); i++) begin
      if (sent_cnt % 24 == 0) calm = ($urandom_range(0, 3) == 0);
      w.in_byte     = text_q[i];
      w.end_of_text = (i == text_q.size() - 1);
      send_word(w);
      sent_cnt++;
    end
    text_q.delete();
  endtask

  // output side: ready runs broken by random stalls
  initial begin
    int run;
    int stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      run = $urandom_range(1, 8);
      repeat (run) @(negedge clk);
      stall = idle_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int nst;
    int cut;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // dropped statement cut at its terminator: end marker only
    put_str("#=ifcFootingType(");
    send_text();
    // byte extremes passed through
    put(8'hFF);
    put(8'h00);
    send_text();
    // text ending inside a prefix: held bytes flushed
    put_str(" #7");
    send_text();

    while (sent_cnt < 360) begin
      nst = $urandom_range(1, 5);
      repeat (nst) add_statement();
      if ($urandom_range(0, 2) == 0) begin
        cut = $urandom_range(1, text_q.size());
        while (text_q.size() > cut) void'(text_q.pop_back());
      end
      send_text();
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4 * HOLD_DEPTH + 20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
